// ----- src/dce_pkg.sv -----
// Shared constants, types and register codes for the delimited column extractor.
package dce_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned FIFO_DEPTH_DEF  = 4;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE   = 8'd10;
  localparam logic [BYTE_W-1:0] DEFAULT_DELIM  = 8'd44;
  localparam logic [BYTE_W-1:0] DEFAULT_ESCAPE = 8'd92;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MASK = 2'd2;

  // One queue entry: the output beats caused by one input byte.
  // A single beat carries first_byte; a pair carries first_byte then second_byte.
  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
  } dce_entry_t;

endpackage

// ----- src/delimited_column_extractor.sv -----
// Top level of the delimited column extractor: front end, entry queue and back end.
// Text arrives one byte per beat on in_byte and is cut into newline-ended lines, each
// split into fields at the delimiter register; an escape byte makes the following
// delimiter literal and stays in the field. Fields whose 1-based column has its bit
// set in column_mask are sent out joined by the delimiter, and a line that sent any
// field is closed by a newline; empty lines and a trailing empty field after a final
// delimiter give nothing. Columns past MAX_COLUMNS are never selected. The input takes
// one byte per clock while the entry queue has room (in_full low); each input byte
// gives zero, one or two output beats, which reach the output ports through the
// entry queue behind any entries still waiting there. The output port moves one byte
// per clock while out_pop is high; sustained input throughput is one byte per cycle
// while the bytes average no more than one output beat each and out_pop stays high,
// and beyond that the single output port sets the pace. Write the configuration
// registers only while no output is pending.
module delimited_column_extractor #(
  parameter int unsigned MAX_COLUMNS = dce_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned FIFO_DEPTH  = dce_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [dce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dce_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [dce_pkg::BYTE_W-1:0]     in_byte,
  // output beats
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [dce_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_run_last
);

  logic                accept;
  logic                wr_en;
  logic                rd_en;
  logic                q_empty;
  dce_pkg::dce_entry_t wr_entry;
  dce_pkg::dce_entry_t head;

  // take a byte whenever the queue can hold whatever it may produce
  assign accept = in_push && !in_full;

  // tokenizer: classify the byte, advance line state, form the entry
  dce_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // decouple the two sides: hold entries until the output drains them
  dce_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_entry(wr_entry),
    .rd_en   (rd_en),
    .rd_entry(head),
    .full    (in_full),
    .empty   (q_empty)
  );

  // output sequencer: one byte per beat, advance within a pair then drop the entry
  dce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .rd_en       (rd_en),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_byte    (out_byte),
    .out_run_last(out_run_last)
  );

endmodule

// ----- src/dce_front.sv -----
// Front end: configuration registers, line tokenizer and result classification.
module dce_front #(
  parameter int unsigned MAX_COLUMNS = dce_pkg::MAX_COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dce_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               accept,
  input  logic [dce_pkg::BYTE_W-1:0]         in_byte,
  output logic                               wr_en,
  output dce_pkg::dce_entry_t                wr_entry
);

  localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 2);

  logic [dce_pkg::BYTE_W-1:0] delim_r;
  logic [dce_pkg::BYTE_W-1:0] escape_r;
  logic [MAX_COLUMNS-1:0]     mask_r;

  logic             escaped_r,  escaped_nxt;
  logic [COL_W-1:0] col_r,      col_nxt;
  logic             fempty_r,   fempty_nxt;
  logic             has_out_r,  has_out_nxt;

  logic is_data;
  logic col_sel;

  always_comb begin
    col_sel = 1'b0;
    for (int k = 0; k < MAX_COLUMNS; k++) begin
      if (col_r == COL_W'(k + 1)) col_sel = mask_r[k];
    end
  end

  always_comb begin
    escaped_nxt  = escaped_r;
    col_nxt      = col_r;
    fempty_nxt   = fempty_r;
    has_out_nxt  = has_out_r;
    is_data      = 1'b0;
    wr_en        = 1'b0;
    wr_entry     = '{two: 1'b0, first_byte: in_byte, second_byte: in_byte};

    if (in_byte == dce_pkg::NEWLINE_BYTE) begin
      // close the line; newline only if something was sent
      wr_entry.first_byte = dce_pkg::NEWLINE_BYTE;
      wr_en               = accept && has_out_r;
      escaped_nxt         = 1'b0;
      col_nxt             = COL_W'(1);
      fempty_nxt          = 1'b1;
      has_out_nxt         = 1'b0;
    end else begin
      if (in_byte == escape_r) begin
        escaped_nxt = 1'b1;
        is_data     = 1'b1;
      end else if (in_byte != delim_r || escaped_r) begin
        escaped_nxt = 1'b0;
        is_data     = 1'b1;
      end

      if (is_data) begin
        if (col_sel) begin
          wr_en = accept;
          if (fempty_r && has_out_r) begin
            wr_entry.two        = 1'b1;
            wr_entry.first_byte = delim_r;
          end
          has_out_nxt = 1'b1;
        end
        fempty_nxt = 1'b0;
      end else begin
        if (col_sel && fempty_r) begin
          wr_entry.first_byte = delim_r;
          wr_en               = accept && has_out_r;
          has_out_nxt         = 1'b1;
        end
        if (col_r <= COL_W'(MAX_COLUMNS)) col_nxt = col_r + COL_W'(1);
        fempty_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r   <= dce_pkg::DEFAULT_DELIM;
      escape_r  <= dce_pkg::DEFAULT_ESCAPE;
      mask_r    <= MAX_COLUMNS'(1);
      escaped_r <= 1'b0;
      col_r     <= COL_W'(1);
      fempty_r  <= 1'b1;
      has_out_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dce_pkg::REG_DELIMITER:   delim_r  <= cfg_data[dce_pkg::BYTE_W-1:0];
          dce_pkg::REG_ESCAPE:      escape_r <= cfg_data[dce_pkg::BYTE_W-1:0];
          dce_pkg::REG_COLUMN_MASK: mask_r   <= cfg_data[MAX_COLUMNS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        escaped_r <= escaped_nxt;
        col_r     <= col_nxt;
        fempty_r  <= fempty_nxt;
        has_out_r <= has_out_nxt;
      end
    end
  end

endmodule

// ----- src/dce_fifo.sv -----
// Short entry queue between the tokenizer and the output sequencer.
module dce_fifo #(
  parameter int unsigned DEPTH = dce_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  dce_pkg::dce_entry_t wr_entry,
  input  logic                rd_en,
  output dce_pkg::dce_entry_t rd_entry,
  output logic                full,
  output logic                empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dce_pkg::dce_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;

  assign full     = (count_r == (AW + 1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (rd_en) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + (AW + 1)'(1);
        2'b01:   count_r <= count_r - (AW + 1)'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full) else $error("entry written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty) else $error("entry read from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW + 1)'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ----- src/dce_back.sv -----
// Back end: expands queue entries into output beats, one byte per beat.
module dce_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dce_pkg::dce_entry_t        head,
  input  logic                       q_empty,
  output logic                       rd_en,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [dce_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_run_last
);

  logic second_r;
  logic beat;

  assign out_empty    = q_empty;
  assign beat         = out_pop && !q_empty;
  assign out_byte     = second_r ? head.second_byte : head.first_byte;
  assign out_run_last = !head.two || second_r;
  assign rd_en        = beat && out_run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (beat) begin
      second_r <= !out_run_last;
    end
  end

  a_pair_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !out_run_last) |=> (!q_empty && second_r))
    else $error("second beat of a pair lost");

  a_second_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (second_r && !q_empty) |-> head.two) else $error("second beat on a single entry");

endmodule

// ----- sim/delimited_column_extractor_tb.sv -----
// Self-checking testbench for the delimited column extractor: queued text against a column predictor.
`timescale 1ns / 100ps

module delimited_column_extractor_tb;

  localparam int unsigned COLUMNS = dce_pkg::MAX_COLUMNS_DEF;
  // The port decodes index 3 as well; writes there must leave every register alone.
  localparam logic [dce_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 80;  // long receiver hold-off, enough to fill the entry queue
  localparam int SETTLE_CYCLES = 8;   // quiet cycles that count as idle

  typedef logic [dce_pkg::BYTE_W-1:0] text_t;
  typedef struct packed {
    text_t value;
    logic  last;
  } beat_t;

  typedef enum int {POP_FREE, POP_COIN, POP_SPARSE, POP_MOSTLY} pop_style_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dce_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dce_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_push;
  logic                           in_full;
  text_t                          in_byte;
  logic                           out_empty;
  logic                           out_pop;
  text_t                          out_byte;
  logic                           out_run_last;

  delimited_column_extractor #(.MAX_COLUMNS(COLUMNS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_byte      (in_byte),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  // Text waiting to be pushed, and output beats the predictor says must come out.
  text_t pending_bytes[$];
  beat_t expected_beats[$];

  // Predictor's own copy of the registers and of the line state.
  text_t       delim_cfg;
  text_t       escape_cfg;
  logic [63:0] mask_cfg;
  logic        in_escape;
  logic [6:0]  col_num;
  logic        field_fresh;
  logic        line_emitted;

  int         errors;
  int         bytes_taken;
  int         beats_seen;
  logic       byte_taken;
  int         burst_left;
  int         gap_left;
  int         hold_req;
  int         hold_seen;
  int         hold_left;
  pop_style_t pop_style;
  int         pop_cycle;
  int         pop_tick;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // Append one byte to the text still to be sent.
  task automatic queue_byte(input text_t b);
    pending_bytes = {pending_bytes, b};
  endtask

  // Work out the beats one text byte gives and advance the line state.
  task automatic predict_byte(input text_t b);
    text_t emit[$];
    logic  as_data;
    logic  picked;
    beat_t nxt;
    as_data = 1'b0;
    if (b == dce_pkg::NEWLINE_BYTE) begin
      // newline wins over delimiter and escape, and clears the escape too
      if (line_emitted)
        emit = {emit, dce_pkg::NEWLINE_BYTE};
      in_escape    = 1'b0;
      col_num      = 7'd1;
      field_fresh  = 1'b1;
      line_emitted = 1'b0;
    end else begin
      // escape is tested first, so an escape equal to the delimiter never splits
      if (b == escape_cfg) begin
        in_escape = 1'b1;
        as_data   = 1'b1;
      end else if (b != delim_cfg || in_escape) begin
        in_escape = 1'b0;
        as_data   = 1'b1;
      end
      picked = 1'b0;
      if (col_num <= COLUMNS)
        picked = mask_cfg[col_num - 7'd1];
      if (as_data) begin
        if (picked) begin
          if (field_fresh && line_emitted)
            emit = {emit, delim_cfg};
          emit = {emit, b};
          line_emitted = 1'b1;
        end
        field_fresh = 1'b0;
      end else begin
        // a bare delimiter closes the field; an empty selected field still counts
        if (picked && field_fresh) begin
          if (line_emitted)
            emit = {emit, delim_cfg};
          line_emitted = 1'b1;
        end
        if (col_num <= COLUMNS)
          col_num++;
        field_fresh = 1'b1;
      end
    end
    foreach (emit[i]) begin
      nxt.value = emit[i];
      nxt.last  = (i == emit.size() - 1);
      expected_beats = {expected_beats, nxt};
    end
  endtask

  // Monitor: check popped beats against the oldest expectation, predict on each pushed byte.
  always @(posedge clk) begin
    beat_t want;
    byte_taken = rst_n && in_push && !in_full;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %h with nothing expected", out_byte));
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %h, wanted %h", out_byte, want.value));
          if (out_run_last !== want.last)
            report_mismatch($sformatf("out_run_last %b, wanted %b", out_run_last, want.last));
        end
      end
      if (byte_taken) begin
        bytes_taken++;
        predict_byte(in_byte);
      end
    end
  end

  // Driver: feed pending bytes in bursts with random gaps; hold a byte until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (byte_taken) begin
        void'(pending_bytes.pop_front());
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          // a third of the bursts run straight on with no gap
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
      end
      if (in_push && !byte_taken) begin
        // hold the offered beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_push <= 1'b1;
        in_byte <= pending_bytes[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Long hold-off counter: restart whenever the stimulus raises a new request.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Receiver: pop on a pattern whose style is redrawn at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (pop_cycle == 0) begin
        pop_style = pop_style_t'($urandom_range(0, 3));
        pop_cycle = $urandom_range(20, 90);
      end else begin
        pop_cycle--;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
      end else begin
        case (pop_style)
          POP_FREE:   out_pop <= 1'b1;
          POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: out_pop <= (pop_tick % 4 == 0);
          default:    out_pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
      pop_tick++;
    end
  end

  // Wait until nothing is queued, offered or expected, then let the block settle.
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      #1;
      if (pending_bytes.size() == 0 && !in_push && expected_beats.size() == 0)
        quiet++;
      else
        quiet = 0;
    end
  endtask

  // Write all three registers, plus the spare index, one beat per falling edge.
  // Junk in the upper bits of the byte-wide registers must be dropped.
  task automatic write_regs(input text_t delim, input text_t esc, input logic [63:0] mask);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(negedge clk);
    cfg_index <= dce_pkg::REG_DELIMITER;
    cfg_data  <= {junk[63:8], delim};
    @(negedge clk);
    cfg_index <= dce_pkg::REG_ESCAPE;
    cfg_data  <= {junk[55:0], esc};
    @(negedge clk);
    cfg_index <= dce_pkg::REG_COLUMN_MASK;
    cfg_data  <= mask;
    @(negedge clk);
    cfg_we    <= 1'b0;
    delim_cfg  = delim;
    escape_cfg = esc;
    mask_cfg   = mask;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i]);
  endtask

  function automatic text_t plain_byte();
    text_t b;
    do
      b = text_t'($urandom_range(0, 255));
    while (b == dce_pkg::NEWLINE_BYTE || b == delim_cfg || b == escape_cfg);
    return b;
  endfunction

  // One well-formed line: random fields, some escapes (before a delimiter or a second
  // escape), now and then a trailing delimiter, closed by a newline.
  task automatic queue_line(input int max_fields);
    int fields;
    int len;
    int r;
    fields = $urandom_range(1, max_fields);
    for (int f = 0; f < fields; f++) begin
      if (f > 0)
        queue_byte(delim_cfg);
      len = $urandom_range(0, 4);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          queue_byte(escape_cfg);
          queue_byte($urandom_range(0, 1) ? delim_cfg : escape_cfg);
        end else begin
          queue_byte(plain_byte());
        end
      end
    end
    if ($urandom_range(0, 7) == 0)
      queue_byte(delim_cfg);
    queue_byte(dce_pkg::NEWLINE_BYTE);
  endtask

  // Mostly well-formed lines; one chunk in six is raw noise over the full byte range.
  task automatic queue_traffic(input int count, input int max_fields);
    int stop;
    stop = pending_bytes.size() + count;
    while (pending_bytes.size() < stop) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 8)) queue_byte(text_t'($urandom_range(0, 255)));
      else
        queue_line(max_fields);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = dce_pkg::REG_DELIMITER;
    cfg_data   = '0;
    in_push    = 1'b0;
    in_byte    = '0;
    out_pop    = 1'b0;
    byte_taken = 1'b0;
    errors     = 0;
    bytes_taken = 0;
    beats_seen = 0;
    burst_left = 12;
    gap_left   = 0;
    hold_req   = 0;
    hold_seen  = 0;
    hold_left  = 0;
    pop_style  = POP_FREE;
    pop_cycle  = 0;
    pop_tick   = 0;
    // registers and line state as they come out of reset
    delim_cfg    = dce_pkg::DEFAULT_DELIM;
    escape_cfg   = dce_pkg::DEFAULT_ESCAPE;
    mask_cfg     = 64'd1;
    in_escape    = 1'b0;
    col_num      = 7'd1;
    field_fresh  = 1'b1;
    line_emitted = 1'b0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed text under the reset settings: only column 1 selected.
    queue_text("\n");          // empty line gives nothing
    queue_text("a,c\n");       // second column dropped
    queue_text(",x\n");        // empty selected field still closes with a newline
    queue_text("a\\,b,c\n");   // escaped delimiter is data
    queue_text("\\\\,z\n");    // a second escape keeps the escape armed
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(dce_pkg::NEWLINE_BYTE);
    queue_text("\\\n");        // newline right after an escape
    queue_text(",k\n");        // escape must not survive the newline
    queue_text("pq");          // leave the line open across the next register writes
    wait_idle();

    // All columns; finish the open line, then a trailing empty field. Hold the
    // receiver off for a long stretch so the queue fills and in_full rises.
    write_regs(dce_pkg::DEFAULT_DELIM, dce_pkg::DEFAULT_ESCAPE, '1);
    queue_text("\n");
    queue_text("a,,b,\n");
    hold_req++;
    queue_traffic(50, 6);
    // sender pauses here until every expected beat has come back
    wait_idle();

    write_regs(8'd9, 8'hFF, {$urandom, $urandom});
    queue_traffic(40, 8);
    wait_idle();

    // Escape equal to the delimiter: that byte never splits.
    begin
      text_t same;
      same = text_t'($urandom_range(0, 255));
      if (same == dce_pkg::NEWLINE_BYTE)
        same = 8'h3B;
      write_regs(same, same, {$urandom, $urandom});
    end
    queue_traffic(40, 6);
    wait_idle();

    // Past the mask width: a line of 71 fields, column 64 selected by the top mask
    // bit; columns after 64 must stay silent.
    write_regs(8'hFF, 8'h00, 64'h8000_0000_0000_0001 | {$urandom, $urandom});
    for (int f = 0; f < 70; f++) begin
      queue_byte(plain_byte());
      queue_byte(delim_cfg);
    end
    queue_byte(plain_byte());
    queue_byte(dce_pkg::NEWLINE_BYTE);
    queue_traffic(10, 70);
    wait_idle();

    // Escape is the newline byte: newline still ends the line.
    write_regs(8'd124, dce_pkg::NEWLINE_BYTE, 64'h5);
    queue_traffic(40, 5);
    wait_idle();

    // Delimiter is the newline byte: lines never split into fields.
    write_regs(dce_pkg::NEWLINE_BYTE, dce_pkg::DEFAULT_ESCAPE, {$urandom, $urandom});
    queue_traffic(25, 4);
    wait_idle();

    // Nothing selected, delimiter and escape at the top of the range.
    write_regs(8'hFF, 8'hFF, 64'd0);
    queue_traffic(20, 6);
    wait_idle();

    write_regs(text_t'($urandom_range(11, 255)), text_t'($urandom_range(0, 9)),
               {$urandom, $urandom});
    queue_traffic(30, 8);
    wait_idle();

    $display("run covered %0d text bytes and %0d output beats over nine register settings",
             bytes_taken, beats_seen);
    $display("settings included escape equal to delimiter, newline as escape and delimiter,"
             , " 70-column lines and a long receiver hold-off");
    if (errors == 0) begin
      $display("delimited_column_extractor_tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("delimited_column_extractor_tb failed");
    end
    $finish;
  end

  // Limit: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("timeout with %0d beats still expected", expected_beats.size());
    $display("delimited_column_extractor_tb failed");
    $finish;
  end

endmodule
